// File: hw/rtl/csh_pkg.sv
// Shared constants, types and the presentation form table for the contextual shaper.
package csh_pkg;

    localparam int POINT_W            = 21;
    localparam int FORM_W             = 16;
    localparam int TABLE_ROWS         = 40;
    localparam int FORM_TABLE_ENTRIES = 40;
    localparam int ACTIVE_ROWS        = (FORM_TABLE_ENTRIES < TABLE_ROWS) ?
                                        FORM_TABLE_ENTRIES : TABLE_ROWS;
    localparam int NON_FWD_COUNT      = 12;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // {key, isolated, initial, medial, final}
    localparam logic [5*FORM_W-1:0] FORM_TABLE [TABLE_ROWS] = '{
        {16'h0621, 16'hFE80, 16'hFE80, 16'hFE80, 16'hFE80},
        {16'h0622, 16'hFE81, 16'hFE81, 16'hFE82, 16'hFE82},
        {16'h0623, 16'hFE83, 16'hFE83, 16'hFE84, 16'hFE84},
        {16'h0624, 16'hFE85, 16'hFE85, 16'hFE86, 16'hFE86},
        {16'h0625, 16'hFE87, 16'hFE87, 16'hFE88, 16'hFE88},
        {16'h0626, 16'hFE89, 16'hFE8B, 16'hFE8C, 16'hFE8A},
        {16'h0627, 16'hFE8D, 16'hFE8D, 16'hFE8E, 16'hFE8E},
        {16'h0628, 16'hFE8F, 16'hFE91, 16'hFE92, 16'hFE90},
        {16'h0629, 16'hFE93, 16'hFE93, 16'hFE94, 16'hFE94},
        {16'h062A, 16'hFE95, 16'hFE97, 16'hFE98, 16'hFE96},
        {16'h062B, 16'hFE99, 16'hFE9B, 16'hFE9C, 16'hFE9A},
        {16'h062C, 16'hFE9D, 16'hFE9F, 16'hFEA0, 16'hFE9E},
        {16'h062D, 16'hFEA1, 16'hFEA3, 16'hFEA4, 16'hFEA2},
        {16'h062E, 16'hFEA5, 16'hFEA7, 16'hFEA8, 16'hFEA6},
        {16'h062F, 16'hFEA9, 16'hFEA9, 16'hFEAA, 16'hFEAA},
        {16'h0630, 16'hFEAB, 16'hFEAB, 16'hFEAC, 16'hFEAC},
        {16'h0631, 16'hFEAD, 16'hFEAD, 16'hFEAE, 16'hFEAE},
        {16'h0632, 16'hFEAF, 16'hFEAF, 16'hFEB0, 16'hFEB0},
        {16'h0633, 16'hFEB1, 16'hFEB3, 16'hFEB4, 16'hFEB2},
        {16'h0634, 16'hFEB5, 16'hFEB7, 16'hFEB8, 16'hFEB6},
        {16'h0635, 16'hFEB9, 16'hFEBB, 16'hFEBC, 16'hFEBA},
        {16'h0636, 16'hFEBD, 16'hFEBF, 16'hFEC0, 16'hFEBE},
        {16'h0637, 16'hFEC1, 16'hFEC3, 16'hFEC4, 16'hFEC2},
        {16'h0638, 16'hFEC5, 16'hFEC7, 16'hFEC8, 16'hFEC6},
        {16'h0639, 16'hFEC9, 16'hFECB, 16'hFECC, 16'hFECA},
        {16'h063A, 16'hFECD, 16'hFECF, 16'hFED0, 16'hFECE},
        {16'h0641, 16'hFED1, 16'hFED3, 16'hFED4, 16'hFED2},
        {16'h0642, 16'hFED5, 16'hFED7, 16'hFED8, 16'hFED6},
        {16'h0643, 16'hFED9, 16'hFEDB, 16'hFEDC, 16'hFEDA},
        {16'h0644, 16'hFEDD, 16'hFEDF, 16'hFEE0, 16'hFEDE},
        {16'h0645, 16'hFEE1, 16'hFEE3, 16'hFEE4, 16'hFEE2},
        {16'h0646, 16'hFEE5, 16'hFEE7, 16'hFEE8, 16'hFEE6},
        {16'h0647, 16'hFEE9, 16'hFEEB, 16'hFEEC, 16'hFEEA},
        {16'h0648, 16'hFEED, 16'hFEED, 16'hFEEE, 16'hFEEE},
        {16'h0649, 16'hFEEF, 16'hFEEF, 16'hFEF0, 16'hFEF0},
        {16'h064A, 16'hFEF1, 16'hFEF3, 16'hFEF4, 16'hFEF2},
        {16'h067E, 16'hFB56, 16'hFB58, 16'hFB59, 16'hFB57},
        {16'h0686, 16'hFB7A, 16'hFB7C, 16'hFB7D, 16'hFB7B},
        {16'h0698, 16'hFB8A, 16'hFB8A, 16'hFB8B, 16'hFB8B},
        {16'h06AF, 16'hFB92, 16'hFB94, 16'hFB95, 16'hFB93}
    };

    // Letters that never join to the letter after them
    localparam logic [FORM_W-1:0] NON_FORWARD [NON_FWD_COUNT] = '{
        16'h0621, 16'h0622, 16'h0623, 16'h0624, 16'h0625, 16'h0627,
        16'h062F, 16'h0630, 16'h0631, 16'h0632, 16'h0648, 16'h0649
    };

    typedef struct packed {
        logic listed;
        logic joins_fwd;
    } t_shape_info;

    typedef struct packed {
        logic [POINT_W-1:0] glyph;
        logic               end_of_run;
    } t_result;

endpackage

// File: hw/rtl/csh_if.sv
// Valid/ready channel interfaces for code points in and glyphs out.
interface csh_in_if;
    logic                          valid;
    logic                          ready;
    logic [csh_pkg::POINT_W-1:0]   code_point;
    logic                          end_of_text;

    modport source (output valid, output code_point, output end_of_text, input ready);
    modport sink   (input valid, input code_point, input end_of_text, output ready);
endinterface

interface csh_out_if;
    logic                          valid;
    logic                          ready;
    logic [csh_pkg::POINT_W-1:0]   glyph;
    logic                          end_of_run;

    modport source (output valid, output glyph, output end_of_run, input ready);
    modport sink   (input valid, input glyph, input end_of_run, output ready);
endinterface

// File: hw/rtl/arabic_contextual_shaper.sv
// Arabic contextual shaper top level: input register, joining decision and result queue.
//
// One code point is accepted per clock while the result queue has room. Each listed
// Arabic letter is replaced by its isolated, initial, medial or final presentation
// form; other code points pass through. The block holds one code point back as
// lookahead, so the glyph for a code point leaves only after the next one of the same
// string has arrived; the item with end_of_text releases the held glyph, if any, and
// its own, the latter marked end_of_run. Results go through an 8-entry queue; input
// is accepted while that queue can take the worst case of two glyphs for the
// registered item and two for the new one, so throughput is one item per cycle when
// the sink keeps up, and a stalled sink holds off the input once the queue no longer
// has that room.
module arabic_contextual_shaper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csh_in_if.sink      i_in,
    csh_out_if.source   o_out
);

    localparam int SUM_W = csh_pkg::FIFO_CW + 1;

    logic                          r_in_valid;
    logic [csh_pkg::POINT_W-1:0]   r_in_point;
    logic                          r_in_last;

    logic                          r_held_valid;
    logic [csh_pkg::POINT_W-1:0]   r_held_point;
    logic                          r_before_joins;
    logic                          n_held_valid;
    logic [csh_pkg::POINT_W-1:0]   n_held_point;
    logic                          n_before_joins;

    logic                          in_accept;
    logic [csh_pkg::FIFO_CW-1:0]   level;
    logic [SUM_W-1:0]              need;

    logic [csh_pkg::POINT_W-1:0]   held_glyph;
    logic [csh_pkg::POINT_W-1:0]   cur_glyph;
    csh_pkg::t_shape_info          held_info;
    csh_pkg::t_shape_info          cur_info;
    logic                          mid_before;

    logic                          push0;
    logic                          push1;
    csh_pkg::t_result              data0;
    csh_pkg::t_result              data1;
    csh_pkg::t_result              held_res;
    csh_pkg::t_result              cur_res;

    // worst case: registered item and new item each release two glyphs
    assign need = {1'b0, level}
                + (r_in_valid ? SUM_W'(2) : SUM_W'(0))
                + SUM_W'(2);
    assign i_in.ready = (need <= SUM_W'(csh_pkg::FIFO_DEPTH));
    assign in_accept  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_point <= i_in.code_point;
            r_in_last  <= i_in.end_of_text;
        end
    end

    csh_shaper u_held_shaper (
        .i_point  (r_held_point),
        .i_before (r_before_joins),
        .i_after  (cur_info.listed),
        .o_glyph  (held_glyph),
        .o_info   (held_info)
    );

    csh_shaper u_cur_shaper (
        .i_point  (r_in_point),
        .i_before (mid_before),
        .i_after  (1'b0),
        .o_glyph  (cur_glyph),
        .o_info   (cur_info)
    );

    // joining state seen by the incoming code point
    assign mid_before = r_held_valid ? held_info.joins_fwd : r_before_joins;

    always_comb begin
        held_res.glyph      = held_glyph;
        held_res.end_of_run = 1'b0;
        cur_res.glyph       = cur_glyph;
        cur_res.end_of_run  = 1'b1;

        push0 = 1'b0;
        push1 = 1'b0;
        data0 = held_res;
        data1 = cur_res;

        n_held_valid   = r_held_valid;
        n_held_point   = r_held_point;
        n_before_joins = r_before_joins;

        if (r_in_valid) begin
            if (r_held_valid) begin
                push0 = 1'b1;
                push1 = r_in_last;
            end else begin
                push0 = r_in_last;
                data0 = cur_res;
            end
            if (r_in_last) begin
                n_held_valid   = 1'b0;
                n_held_point   = '0;
                n_before_joins = 1'b0;
            end else begin
                n_held_valid   = 1'b1;
                n_held_point   = r_in_point;
                n_before_joins = mid_before;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid   <= 1'b0;
            r_held_point   <= '0;
            r_before_joins <= 1'b0;
        end else begin
            r_held_valid   <= n_held_valid;
            r_held_point   <= n_held_point;
            r_before_joins <= n_before_joins;
        end
    end

    csh_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .i_data0 (data0),
        .i_data1 (data1),
        .o_level (level),
        .o_out   (o_out)
    );

endmodule

// File: hw/rtl/csh_shaper.sv
// Table lookup of one code point: presentation form for the given context, plus joining class.
module csh_shaper (
    input  logic [csh_pkg::POINT_W-1:0] i_point,
    input  logic                        i_before,
    input  logic                        i_after,
    output logic [csh_pkg::POINT_W-1:0] o_glyph,
    output csh_pkg::t_shape_info        o_info
);

    logic                        hit;
    logic                        non_fwd;
    logic [csh_pkg::FORM_W-1:0]  form;
    logic [5*csh_pkg::FORM_W-1:0] row;
    logic                        upper_zero;

    assign upper_zero = (i_point[csh_pkg::POINT_W-1:csh_pkg::FORM_W] == '0);

    always_comb begin
        hit     = 1'b0;
        non_fwd = 1'b0;
        form    = '0;
        row     = '0;
        for (int i = 0; i < csh_pkg::TABLE_ROWS; i++) begin
            if (i < csh_pkg::ACTIVE_ROWS && upper_zero &&
                csh_pkg::FORM_TABLE[i][5*csh_pkg::FORM_W-1 -: csh_pkg::FORM_W] ==
                i_point[csh_pkg::FORM_W-1:0]) begin
                hit = 1'b1;
                row = csh_pkg::FORM_TABLE[i];
            end
        end
        for (int k = 0; k < csh_pkg::NON_FWD_COUNT; k++) begin
            if (upper_zero && csh_pkg::NON_FORWARD[k] == i_point[csh_pkg::FORM_W-1:0]) begin
                non_fwd = 1'b1;
            end
        end
        // row fields from the top: key, isolated, initial, medial, final
        if (i_before && i_after) begin
            form = row[2*csh_pkg::FORM_W-1 -: csh_pkg::FORM_W];
        end else if (i_before) begin
            form = row[csh_pkg::FORM_W-1:0];
        end else if (i_after) begin
            form = row[3*csh_pkg::FORM_W-1 -: csh_pkg::FORM_W];
        end else begin
            form = row[4*csh_pkg::FORM_W-1 -: csh_pkg::FORM_W];
        end
    end

    assign o_glyph          = hit ? {{(csh_pkg::POINT_W-csh_pkg::FORM_W){1'b0}}, form} : i_point;
    assign o_info.listed    = hit;
    assign o_info.joins_fwd = hit && !non_fwd;

endmodule

// File: hw/rtl/csh_out_fifo.sv
// Result queue: takes up to two glyphs per cycle, hands out one per cycle while the sink is ready.
module csh_out_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push0,
    input  logic                         i_push1,
    input  csh_pkg::t_result             i_data0,
    input  csh_pkg::t_result             i_data1,
    output logic [csh_pkg::FIFO_CW-1:0]  o_level,
    csh_out_if.source                    o_out
);

    csh_pkg::t_result                r_mem [csh_pkg::FIFO_DEPTH];
    logic [csh_pkg::FIFO_AW-1:0]     r_head;
    logic [csh_pkg::FIFO_AW-1:0]     r_tail;
    logic [csh_pkg::FIFO_CW-1:0]     r_count;
    logic [csh_pkg::FIFO_AW-1:0]     n_head;
    logic [csh_pkg::FIFO_AW-1:0]     n_tail;
    logic [csh_pkg::FIFO_CW-1:0]     n_count;
    logic [csh_pkg::FIFO_AW-1:0]     tail_plus1;
    logic                            pop;
    logic [csh_pkg::FIFO_CW-1:0]     push_n;

    assign pop        = o_out.valid && o_out.ready;
    assign tail_plus1 = r_tail + 1'b1;
    // i_push1 is only raised together with i_push0
    assign push_n     = {{(csh_pkg::FIFO_CW-1){1'b0}}, i_push0} +
                        {{(csh_pkg::FIFO_CW-1){1'b0}}, i_push1};

    always_comb begin
        n_head  = pop ? r_head + 1'b1 : r_head;
        n_tail  = r_tail + push_n[csh_pkg::FIFO_AW-1:0];
        n_count = r_count + push_n - {{(csh_pkg::FIFO_CW-1){1'b0}}, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_tail] <= i_data0;
        end
        if (i_push1) begin
            r_mem[tail_plus1] <= i_data1;
        end
    end

    assign o_out.valid      = (r_count != '0);
    assign o_out.glyph      = r_mem[r_head].glyph;
    assign o_out.end_of_run = r_mem[r_head].end_of_run;
    assign o_level          = r_count;

endmodule
